// ----- src/mmfrl_pkg.sv -----
`timescale 1ns / 1ps
package mmfrl_pkg;

    localparam int FLOW_COUNT = 64;
    localparam int FLOW_BITS  = 6;
    localparam int RING_SLOTS = 16;
    localparam int RING_BITS  = 4;
    localparam int FILL_BITS  = 5;
    localparam int TIME_BITS  = 48;
    localparam int FTIME_BITS = 50;
    localparam int AMT_BITS   = 49;
    localparam int DVD_BITS   = 52;
    localparam int DVS_BITS   = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BURST = 2'd3;

    typedef enum logic [1:0] {
        MODE_TB   = 2'd0,
        MODE_FW   = 2'd1,
        MODE_SW   = 2'd2,
        MODE_GCRA = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_PREP,
        OP_ERR,
        OP_TB_MUL,
        OP_TB_ADD,
        OP_TB_DIV,
        OP_TB_FIN,
        OP_FW,
        OP_SW_CHK,
        OP_SW_FIN,
        OP_GC_DIV0,
        OP_GC_MUL,
        OP_GC_CHK,
        OP_GC_DIV1,
        OP_GC_FIN
    } t_op;

    typedef struct packed {
        logic [FLOW_BITS-1:0] flow_index;
        logic [TIME_BITS-1:0] now_ticks;
    } t_in;

    typedef struct packed {
        logic                 allowed;
        logic [15:0]          remaining;
        logic [TIME_BITS-1:0] retry_ticks;
        logic                 config_error;
    } t_out;

    typedef struct packed {
        t_op  op;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic  cfg_err;
        t_mode mode;
        logic  pop;
        logic  gc_rej;
        logic  div_done;
        logic  out_free;
    } t_sts;

    function automatic logic [TIME_BITS-1:0] sat_time(input logic [TIME_BITS+2:0] v);
        return (v[TIME_BITS+2:TIME_BITS] != 3'd0) ? {TIME_BITS{1'b1}} : v[TIME_BITS-1:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [DVD_BITS-1:0] v);
        return (v[DVD_BITS-1:16] != '0) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

// ----- src/mmfrl_div.sv -----
`timescale 1ns / 1ps
module mmfrl_div
    import mmfrl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DVD_BITS-1:0] i_dividend,
    input  logic [DVS_BITS-1:0] i_divisor,
    output logic [DVD_BITS-1:0] o_quot,
    output logic                o_done
);

    logic                r_busy;
    logic                r_done;
    logic [5:0]          r_cnt;
    logic [DVS_BITS-1:0] r_rem;
    logic [DVD_BITS-1:0] r_q;
    logic [DVS_BITS-1:0] r_dvs;
    logic [DVS_BITS:0]   w_sh;
    logic                w_ge;
    logic [DVS_BITS:0]   w_rem;

    always_comb begin
        w_sh  = {r_rem, r_q[DVD_BITS-1]};
        w_ge  = w_sh >= {1'b0, r_dvs};
        w_rem = w_ge ? (w_sh - {1'b0, r_dvs}) : w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DVD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem[DVS_BITS-1:0];
            r_q   <= {r_q[DVD_BITS-2:0], w_ge};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// ----- src/mmfrl_dp.sv -----
`timescale 1ns / 1ps
module mmfrl_dp
    import mmfrl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  t_in                      i_in,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output t_out                     o_out,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef struct packed {
        t_mode                 mode;
        logic [RING_BITS-1:0]  head;
        logic [FILL_BITS-1:0]  fill;
        logic [FTIME_BITS-1:0] ftime;
        logic [AMT_BITS-1:0]   amount;
    } t_flow;

    t_mode       r_mode;
    logic [15:0] r_limit;
    logic [31:0] r_win;
    logic [15:0] r_burst;

    logic [FLOW_COUNT-1:0] r_fvalid;
    t_flow                 mem_flow [FLOW_COUNT];
    t_flow                 r_frd;
    logic [TIME_BITS-1:0]  mem_stamp [FLOW_COUNT*RING_SLOTS];
    logic [TIME_BITS-1:0]  r_stamp;

    logic [FLOW_BITS-1:0]  r_flow, n_flow;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [FTIME_BITS-1:0] r_time, n_time;
    logic [AMT_BITS-1:0]   r_amt, n_amt;
    logic [RING_BITS-1:0]  r_head, n_head;
    logic [FILL_BITS-1:0]  r_fill, n_fill;
    logic [TIME_BITS-1:0]  r_capc, n_capc;
    logic [TIME_BITS-1:0]  r_el, n_el;
    logic                  r_gt, n_gt;
    logic                  r_short, n_short;
    logic [63:0]           r_prod, n_prod;
    logic [31:0]           r_int, n_int;
    logic [TIME_BITS-1:0]  r_tol, n_tol;
    t_out                  r_res, n_res;
    logic                  r_out_valid;
    t_out                  r_out;

    logic [15:0]           w_cap;
    logic                  w_err;
    logic [TIME_BITS-1:0]  w_capc;
    logic [FILL_BITS-1:0]  w_eff;
    logic                  w_pop;
    logic [TIME_BITS:0]    w_gc_lim;
    logic                  w_gc_rej;
    logic                  w_fwe;
    t_flow                 w_fwd;
    logic                  w_swe;
    logic [FLOW_BITS+RING_BITS-1:0] w_swa;
    logic                  w_sre;
    logic [FLOW_BITS+RING_BITS-1:0] w_sra;
    logic                  w_div_start;
    logic [DVD_BITS-1:0]   w_dvd;
    logic [DVS_BITS-1:0]   w_dvs;
    logic [DVD_BITS-1:0]   w_q;
    logic                  w_div_done;

    logic                  v_fresh;
    logic [FTIME_BITS-1:0] v_tsel;
    logic [FTIME_BITS-1:0] v_now50;
    logic [FTIME_BITS-1:0] v_start;
    logic [AMT_BITS-1:0]   v_used;
    logic [TIME_BITS+2:0]  v_ret;
    logic [64:0]           v_sum;
    logic [FTIME_BITS-1:0] v_max;

    mmfrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_quot     (w_q),
        .o_done     (w_div_done)
    );

    always_comb begin
        w_cap    = (r_burst != 16'd0) ? r_burst : r_limit;
        w_err    = (r_limit == 16'd0) || (r_win == 32'd0) ||
                   ((r_mode == MODE_GCRA) && (r_win < {16'd0, r_limit}));
        w_capc   = TIME_BITS'(r_win * w_cap);
        w_eff    = (r_limit < 16'(RING_SLOTS)) ? r_limit[FILL_BITS-1:0]
                                               : FILL_BITS'(RING_SLOTS);
        w_pop    = (r_fill != '0) && (r_now >= r_stamp) &&
                   ((r_now - r_stamp) >= {16'd0, r_win});
        w_gc_lim = {1'b0, r_now} + {1'b0, r_tol};
        w_gc_rej = {1'b0, w_gc_lim} < r_time;
    end

    always_comb begin
        n_flow  = r_flow;
        n_now   = r_now;
        n_time  = r_time;
        n_amt   = r_amt;
        n_head  = r_head;
        n_fill  = r_fill;
        n_capc  = r_capc;
        n_el    = r_el;
        n_gt    = r_gt;
        n_short = r_short;
        n_prod  = r_prod;
        n_int   = r_int;
        n_tol   = r_tol;
        n_res   = r_res;
        w_fwe   = 1'b0;
        w_fwd   = '{mode: r_mode, head: r_head, fill: r_fill, ftime: r_time, amount: r_amt};
        w_swe   = 1'b0;
        w_swa   = {r_flow, r_head};
        w_sre   = 1'b0;
        w_sra   = {r_flow, r_head};
        w_div_start = 1'b0;
        w_dvd   = '0;
        w_dvs   = '0;
        v_now50 = {2'd0, r_now};
        v_fresh = !r_fvalid[r_flow] || (r_frd.mode != r_mode);
        v_tsel  = v_fresh ? v_now50 : r_frd.ftime;
        v_start = r_time;
        v_used  = r_amt;
        v_ret   = '0;
        v_sum   = {1'b0, r_prod} + {16'd0, r_amt};
        v_max   = (r_time > v_now50) ? r_time : v_now50;
        case (i_cmd.op)
            OP_LOAD: begin
                n_flow = i_in.flow_index;
                n_now  = i_in.now_ticks;
            end
            OP_PREP: begin
                n_time = v_tsel;
                if (v_fresh) begin
                    n_amt  = (r_mode == MODE_TB) ? {1'b0, w_capc} : '0;
                    n_head = '0;
                    n_fill = '0;
                end else begin
                    n_amt  = r_frd.amount;
                    n_head = r_frd.head;
                    n_fill = r_frd.fill;
                end
                n_capc = w_capc;
                n_gt   = v_now50 > v_tsel;
                n_el   = r_now - v_tsel[TIME_BITS-1:0];
                w_sre  = 1'b1;
                w_sra  = {r_flow, (v_fresh ? RING_BITS'(0) : r_frd.head)};
            end
            OP_ERR: begin
                n_res = '{allowed: 1'b0, remaining: 16'd0, retry_ticks: '0, config_error: 1'b1};
            end
            OP_TB_MUL: begin
                n_prod = r_el * r_limit;
            end
            OP_TB_ADD: begin
                if (r_gt) begin
                    n_amt  = (v_sum > {17'd0, r_capc}) ? {1'b0, r_capc} : v_sum[AMT_BITS-1:0];
                    n_time = v_now50;
                end
            end
            OP_TB_DIV: begin
                w_div_start = 1'b1;
                n_short = r_amt < {17'd0, r_win};
                if (r_amt < {17'd0, r_win}) begin
                    w_dvd = {20'd0, r_win} - {3'd0, r_amt} + {36'd0, r_limit} - 52'd1;
                    w_dvs = {16'd0, r_limit};
                end else begin
                    n_amt = r_amt - {17'd0, r_win};
                    w_dvd = {3'd0, r_amt - {17'd0, r_win}};
                    w_dvs = r_win;
                end
            end
            OP_TB_FIN: begin
                if (r_short) begin
                    n_res = '{allowed: 1'b0, remaining: 16'd0,
                              retry_ticks: sat_time(w_q[TIME_BITS+2:0]), config_error: 1'b0};
                end else begin
                    n_res = '{allowed: 1'b1, remaining: sat16(w_q),
                              retry_ticks: '0, config_error: 1'b0};
                end
                w_fwe = 1'b1;
            end
            OP_FW: begin
                if ((v_now50 >= r_time) && ((v_now50 - r_time) >= {18'd0, r_win})) begin
                    v_start = v_now50;
                    v_used  = '0;
                end
                if (v_used >= {33'd0, r_limit}) begin
                    if (v_now50 >= v_start) begin
                        v_ret = {19'd0, r_win} - ({1'b0, v_now50} - {1'b0, v_start});
                    end else begin
                        v_ret = {19'd0, r_win} + ({1'b0, v_start} - {1'b0, v_now50});
                    end
                    n_res = '{allowed: 1'b0, remaining: 16'd0,
                              retry_ticks: sat_time(v_ret), config_error: 1'b0};
                end else begin
                    v_used = v_used + 49'd1;
                    n_res  = '{allowed: 1'b1, remaining: r_limit - v_used[15:0],
                               retry_ticks: '0, config_error: 1'b0};
                end
                w_fwe = 1'b1;
                w_fwd.ftime  = v_start;
                w_fwd.amount = v_used;
            end
            OP_SW_CHK: begin
                if (w_pop) begin
                    n_head = r_head + RING_BITS'(1);
                    n_fill = r_fill - FILL_BITS'(1);
                    w_sre  = 1'b1;
                    w_sra  = {r_flow, r_head + RING_BITS'(1)};
                end
            end
            OP_SW_FIN: begin
                if (r_fill >= w_eff) begin
                    v_ret = {3'd0, r_stamp} + {19'd0, r_win} - {3'd0, r_now};
                    n_res = '{allowed: 1'b0, remaining: 16'd0,
                              retry_ticks: sat_time(v_ret), config_error: 1'b0};
                end else begin
                    w_swe  = 1'b1;
                    w_swa  = {r_flow, r_head + r_fill[RING_BITS-1:0]};
                    n_fill = r_fill + FILL_BITS'(1);
                    n_res  = '{allowed: 1'b1,
                               remaining: {11'd0, w_eff - (r_fill + FILL_BITS'(1))},
                               retry_ticks: '0, config_error: 1'b0};
                end
                w_fwe = 1'b1;
                w_fwd.fill = n_fill;
            end
            OP_GC_DIV0: begin
                w_div_start = 1'b1;
                w_dvd = {20'd0, r_win};
                w_dvs = {16'd0, r_limit};
            end
            OP_GC_MUL: begin
                n_int = w_q[31:0];
                n_tol = w_q[31:0] * (w_cap - 16'd1);
            end
            OP_GC_CHK: begin
                if (w_gc_rej) begin
                    v_ret = {1'b0, r_time} - {2'd0, w_gc_lim};
                    n_res = '{allowed: 1'b0, remaining: 16'd0,
                              retry_ticks: sat_time(v_ret), config_error: 1'b0};
                    w_fwe = 1'b1;
                end else begin
                    n_time = v_max + {18'd0, r_int};
                end
            end
            OP_GC_DIV1: begin
                w_div_start = 1'b1;
                w_dvd = {2'd0, r_time} - {4'd0, r_now} + {20'd0, r_int} - 52'd1;
                w_dvs = r_int;
            end
            OP_GC_FIN: begin
                n_res = '{allowed: 1'b1,
                          remaining: ({36'd0, w_cap} > w_q) ? (w_cap - w_q[15:0]) : 16'd0,
                          retry_ticks: '0, config_error: 1'b0};
                w_fwe = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TB;
            r_limit     <= 16'd100;
            r_win       <= 32'd1000000;
            r_burst     <= 16'd0;
            r_fvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[1:0]);
                    CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                    CFG_WIN:   r_win   <= i_cfg_data;
                    CFG_BURST: r_burst <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (w_fwe) begin
                r_fvalid[r_flow] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flow  <= n_flow;
        r_now   <= n_now;
        r_time  <= n_time;
        r_amt   <= n_amt;
        r_head  <= n_head;
        r_fill  <= n_fill;
        r_capc  <= n_capc;
        r_el    <= n_el;
        r_gt    <= n_gt;
        r_short <= n_short;
        r_prod  <= n_prod;
        r_int   <= n_int;
        r_tol   <= n_tol;
        r_res   <= n_res;
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) begin
            mem_flow[r_flow] <= w_fwd;
        end
        if (i_cmd.op == OP_LOAD) begin
            r_frd <= mem_flow[i_in.flow_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            mem_stamp[w_swa] <= r_now;
        end
        if (w_sre) begin
            r_stamp <= mem_stamp[w_sra];
        end
    end

    always_comb begin
        o_sts.cfg_err  = w_err;
        o_sts.mode     = r_mode;
        o_sts.pop      = w_pop;
        o_sts.gc_rej   = w_gc_rej;
        o_sts.div_done = w_div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- src/mmfrl_ctrl.sv -----
`timescale 1ns / 1ps
module mmfrl_ctrl
    import mmfrl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_ERR,
        S_TB_MUL, S_TB_ADD, S_TB_DIV, S_TB_WAIT, S_TB_FIN,
        S_FW,
        S_SW_CHK, S_SW_FIN,
        S_GC_DIV0, S_GC_W0, S_GC_MUL, S_GC_CHK, S_GC_DIV1, S_GC_W1, S_GC_FIN,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_IDLE;
        o_cmd.push   = 1'b0;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                if (i_sts.cfg_err) begin
                    n_state = S_ERR;
                end else begin
                    case (i_sts.mode)
                        MODE_TB:   n_state = S_TB_MUL;
                        MODE_FW:   n_state = S_FW;
                        MODE_SW:   n_state = S_SW_CHK;
                        MODE_GCRA: n_state = S_GC_DIV0;
                        default:   n_state = S_ERR;
                    endcase
                end
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = S_OUT;
            end
            S_TB_MUL: begin
                o_cmd.op = OP_TB_MUL;
                n_state  = S_TB_ADD;
            end
            S_TB_ADD: begin
                o_cmd.op = OP_TB_ADD;
                n_state  = S_TB_DIV;
            end
            S_TB_DIV: begin
                o_cmd.op = OP_TB_DIV;
                n_state  = S_TB_WAIT;
            end
            S_TB_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_TB_FIN;
                end
            end
            S_TB_FIN: begin
                o_cmd.op = OP_TB_FIN;
                n_state  = S_OUT;
            end
            S_FW: begin
                o_cmd.op = OP_FW;
                n_state  = S_OUT;
            end
            S_SW_CHK: begin
                o_cmd.op = OP_SW_CHK;
                if (!i_sts.pop) begin
                    n_state = S_SW_FIN;
                end
            end
            S_SW_FIN: begin
                o_cmd.op = OP_SW_FIN;
                n_state  = S_OUT;
            end
            S_GC_DIV0: begin
                o_cmd.op = OP_GC_DIV0;
                n_state  = S_GC_W0;
            end
            S_GC_W0: begin
                if (i_sts.div_done) begin
                    n_state = S_GC_MUL;
                end
            end
            S_GC_MUL: begin
                o_cmd.op = OP_GC_MUL;
                n_state  = S_GC_CHK;
            end
            S_GC_CHK: begin
                o_cmd.op = OP_GC_CHK;
                n_state  = i_sts.gc_rej ? S_OUT : S_GC_DIV1;
            end
            S_GC_DIV1: begin
                o_cmd.op = OP_GC_DIV1;
                n_state  = S_GC_W1;
            end
            S_GC_W1: begin
                if (i_sts.div_done) begin
                    n_state = S_GC_FIN;
                end
            end
            S_GC_FIN: begin
                o_cmd.op = OP_GC_FIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_push_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> (r_state == S_IDLE))
        else $error("result push not followed by idle");

    a_no_stray_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT || r_state == S_PREP) |-> !i_sts.div_done)
        else $error("divider finished outside a wait state");

    a_err_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP && i_sts.cfg_err) |=> (r_state == S_ERR))
        else $error("bad configuration not reported");

endmodule

// ----- src/multi_mode_flow_rate_limiter_unit.sv -----
`timescale 1ns / 1ps
// Per-flow request limiter: token bucket, fixed window, sliding window or GCRA.
// Input channel (i_in_valid/o_in_ready, i_in): one beat per request, carrying
// flow index and timestamp. Output channel (o_out_valid/i_out_ready, o_out):
// one beat per request with allowed, remaining, retry_ticks, config_error.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): always
// ready; write only while no request is in flight.
// One request is worked at a time. Fixed window answers directly, sliding
//   window first pops every expired stamp, token bucket takes one pass of the
//   radix-2 divider, and GCRA takes two passes when admitted and one when
//   rejected. Bad configuration goes straight to the error result.
// Throughput: the next request is accepted the cycle after a result is pushed.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls, a second result holds the engine
// until the output register frees.
// Reset: configuration registers return to their defaults and all flows read
// as new; no clearing pass is needed.
module multi_mode_flow_rate_limiter_unit
    import mmfrl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in                      i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out                     o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    mmfrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    mmfrl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
